[rtl/core/assert_macros.svh]
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRCR_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CRCR_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/crcr_pkg.sv]
// Types and constants shared by the centreline resampler modules.
package crcr_pkg;

  localparam int MAX_STEPS = 31;
  localparam int KW     = 5;    // step and vertex index width
  localparam int PW     = 32;   // position width
  localparam int AW     = 16;   // attribute width
  localparam int MW     = 8;    // material width
  localparam int NATTR  = 5;    // interpolated attributes
  localparam int TDW    = 184;  // packed item width
  localparam int COEFW  = 37;   // spline coefficient / multiplier operand width
  localparam int PRODW  = 74;   // multiplier product width
  localparam int ACCW   = 64;   // numerator accumulator width
  localparam int DISTW  = 66;   // squared chord width
  localparam int SQW    = 75;   // squared step length width
  localparam int MONOW  = 15;   // monomial width (up to 31 cubed)
  localparam int DENW   = 17;   // divisor width
  localparam int QW     = 36;   // quotient bits produced
  localparam int RW     = 18;   // partial remainder width

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_LOAD, OP_COEF, OP_SQX, OP_SQZ, OP_SQL, OP_SINIT,
    OP_SSTEP, OP_NPOW1, OP_NPOW2, OP_MONO1, OP_MONO2, OP_PMAC, OP_PACC,
    OP_PDIV, OP_PSAVE, OP_AMUL, OP_ADIV, OP_ASAVE, OP_TAIL, OP_SHIFT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_LOAD, ST_COEF, ST_SQX, ST_SQZ, ST_SQL, ST_SINIT,
    ST_SCHK, ST_NPOW1, ST_NPOW2, ST_MONO1, ST_MONO2, ST_PMAC, ST_PACC,
    ST_PDIV, ST_PWAIT, ST_AMUL, ST_ADIV, ST_AWAIT, ST_OUT, ST_TAIL, ST_TOUT,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    dp_op_t        op;
    logic          seg_end;    // segment that ends on the input point
    logic          far_start;  // start neighbour is the older stored point
    logic [1:0]    axis;
    logic [2:0]    attr;
    logic [1:0]    term;
    logic [KW-1:0] k;
    logic [KW-1:0] n;
  } cmd_t;

  typedef struct packed {
    logic reached;   // squared step length covers the chord
    logic div_done;  // divider result ready
  } status_t;

endpackage

[rtl/core/crcr_div.sv]
// Bit-serial floor divider of a signed numerator by a positive divisor.
module crcr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [crcr_pkg::ACCW-1:0]  num,
  input  logic        [crcr_pkg::DENW-1:0]  den,
  output logic                              done,
  output logic signed [crcr_pkg::QW:0]      quo
);

  logic                        busy;
  logic                        neg;
  logic [5:0]                  cnt;
  logic [crcr_pkg::RW-1:0]     rem;
  logic [crcr_pkg::QW-1:0]     qsh;
  logic [crcr_pkg::DENW-1:0]   dreg;
  logic [crcr_pkg::ACCW-1:0]   mag;
  logic [crcr_pkg::RW-1:0]     trial;
  logic                        ge;

  // magnitude of the numerator and one restoring step
  always_comb begin
    mag   = num[crcr_pkg::ACCW-1] ? crcr_pkg::ACCW'(-num) : crcr_pkg::ACCW'(num);
    trial = {rem[crcr_pkg::RW-2:0], qsh[crcr_pkg::QW-1]};
    ge    = trial >= {1'b0, dreg};
  end

  // control: load, iterate one bit a cycle, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(crcr_pkg::QW);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 6'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, quotient shift and signed floor result
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[crcr_pkg::ACCW-1];
      dreg <= den;
      rem  <= mag[crcr_pkg::QW+crcr_pkg::RW-1:crcr_pkg::QW];
      qsh  <= mag[crcr_pkg::QW-1:0];
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= ge ? trial - {1'b0, dreg} : trial;
        qsh <= {qsh[crcr_pkg::QW-2:0], ge};
      end else if (neg) begin
        quo <= -$signed({1'b0, qsh}) - $signed({{crcr_pkg::QW{1'b0}}, |rem});
      end else begin
        quo <= $signed({1'b0, qsh});
      end
    end
  end

endmodule

[rtl/core/crcr_datapath.sv]
// Datapath: point history, step search, spline and attribute evaluation.
module crcr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  input  logic [crcr_pkg::TDW-1:0]     in_data,
  input  crcr_pkg::cmd_t               cmd,
  output crcr_pkg::status_t            status,
  output logic [crcr_pkg::TDW-1:0]     out_data
);

  localparam int PW    = crcr_pkg::PW;
  localparam int AW    = crcr_pkg::AW;
  localparam int MW    = crcr_pkg::MW;
  localparam int NA    = crcr_pkg::NATTR;
  localparam int CW    = crcr_pkg::COEFW;
  localparam int ACCW  = crcr_pkg::ACCW;
  localparam int MONOW = crcr_pkg::MONOW;
  localparam int KW    = crcr_pkg::KW;

  logic [31:0]                 step_len;
  logic signed [PW-1:0]        ip [3];
  logic [AW-1:0]               ia [NA];
  logic [MW-1:0]               imat;
  logic signed [PW-1:0]        hp0 [3];
  logic signed [PW-1:0]        hp1 [3];
  logic signed [PW-1:0]        hp2 [3];
  logic [AW-1:0]               ha0 [NA];
  logic [AW-1:0]               ha1 [NA];
  logic [MW-1:0]               hm0, hm1;
  logic signed [PW-1:0]        pa [3];
  logic signed [PW-1:0]        pb [3];
  logic signed [PW-1:0]        pc [3];
  logic signed [PW-1:0]        pd [3];
  logic [AW-1:0]               fa [NA];
  logic [AW-1:0]               ta [NA];
  logic [MW-1:0]               fmat, tmat;
  logic signed [CW-1:0]        coef [3][4];
  logic signed [CW-1:0]        coef_next [3][4];
  logic signed [PW:0]          dx, dz;
  logic signed [AW:0]          adiff [NA];
  logic signed [crcr_pkg::PRODW-1:0] prod;
  logic signed [CW-1:0]        mul_a, mul_b;
  logic [crcr_pkg::DISTW-1:0]  d2;
  logic [crcr_pkg::SQW-1:0]    ssum, sstep, sinc, lsq;
  logic [2*KW-1:0]             n2, k2;
  logic [MONOW-1:0]            n3, k3, kn2, k2n;
  logic [MONOW-1:0]            mono;
  logic signed [ACCW-1:0]      acc;
  logic signed [ACCW-1:0]      div_num;
  logic [crcr_pkg::DENW-1:0]   div_den;
  logic                        div_start;
  logic                        div_done;
  logic signed [crcr_pkg::QW:0] div_q;
  logic [PW-1:0]               qsat;
  logic signed [PW-1:0]        opos [3];
  logic [AW-1:0]               oattr [NA];
  logic [MW-1:0]               omat;
  logic signed [CW-1:0]        ea [3];
  logic signed [CW-1:0]        eb [3];
  logic signed [CW-1:0]        ec [3];
  logic signed [CW-1:0]        ed [3];

  // spline coefficients of the loaded segment, one set per axis
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ea[j] = {{(CW-PW){pa[j][PW-1]}}, pa[j]};
      eb[j] = {{(CW-PW){pb[j][PW-1]}}, pb[j]};
      ec[j] = {{(CW-PW){pc[j][PW-1]}}, pc[j]};
      ed[j] = {{(CW-PW){pd[j][PW-1]}}, pd[j]};
      coef_next[j][0] = eb[j] + eb[j];
      coef_next[j][1] = ec[j] - ea[j];
      coef_next[j][2] = ea[j] + ea[j] - (eb[j] <<< 2) - eb[j] + (ec[j] <<< 2) - ed[j];
      coef_next[j][3] = eb[j] + eb[j] + eb[j] - ea[j] - ec[j] - ec[j] - ec[j] + ed[j];
    end
  end

  // monomial for the current numerator term
  always_comb begin
    case (cmd.term)
      2'd0:    mono = n3;
      2'd1:    mono = kn2;
      2'd2:    mono = k2n;
      default: mono = k3;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      crcr_pkg::OP_SQX: begin
        mul_a = {{(CW-PW-1){dx[PW]}}, dx};
        mul_b = {{(CW-PW-1){dx[PW]}}, dx};
      end
      crcr_pkg::OP_SQZ: begin
        mul_a = {{(CW-PW-1){dz[PW]}}, dz};
        mul_b = {{(CW-PW-1){dz[PW]}}, dz};
      end
      crcr_pkg::OP_SQL: begin
        mul_a = {{(CW-32){1'b0}}, step_len};
        mul_b = {{(CW-32){1'b0}}, step_len};
      end
      crcr_pkg::OP_PMAC: begin
        mul_a = coef[cmd.axis][cmd.term];
        mul_b = {{(CW-MONOW){1'b0}}, mono};
      end
      crcr_pkg::OP_AMUL: begin
        mul_a = {{(CW-AW-1){adiff[cmd.attr][AW]}}, adiff[cmd.attr]};
        mul_b = {{(CW-KW){1'b0}}, cmd.k};
      end
      default: ;
    endcase
  end

  // divider operands: position and attribute rounding
  always_comb begin
    div_start = (cmd.op == crcr_pkg::OP_PDIV) || (cmd.op == crcr_pkg::OP_ADIV);
    if (cmd.op == crcr_pkg::OP_PDIV) begin
      div_num = (acc <<< 1) + $signed({{(ACCW-MONOW-1){1'b0}}, n3, 1'b0});
      div_den = {n3, 2'b00};
    end else begin
      div_num = (prod[ACCW-1:0] <<< 1) + $signed({{(ACCW-KW){1'b0}}, cmd.n});
      div_den = {{(crcr_pkg::DENW-KW-1){1'b0}}, cmd.n, 1'b0};
    end
  end

  // saturate the position quotient to the signed 32 bit range
  always_comb begin
    if (!div_q[crcr_pkg::QW] && (|div_q[crcr_pkg::QW-1:PW-1])) begin
      qsat = {1'b0, {(PW-1){1'b1}}};
    end else if (div_q[crcr_pkg::QW] && !(&div_q[crcr_pkg::QW-1:PW-1])) begin
      qsat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      qsat = div_q[PW-1:0];
    end
    lsq = {{(crcr_pkg::SQW-64){1'b0}}, prod[63:0]};
  end

  crcr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign status.reached  = ssum >= {{(crcr_pkg::SQW-crcr_pkg::DISTW){1'b0}}, d2};
  assign status.div_done = div_done;

  // step length register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_len <= 32'd256;
    end else if (cfg_we) begin
      step_len <= cfg_wdata;
    end
  end

  // multiplier result register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // command-driven datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      crcr_pkg::OP_LATCH: begin
        for (int j = 0; j < 3; j++) ip[j] <= in_data[j*PW +: PW];
        for (int j = 0; j < NA; j++) ia[j] <= in_data[3*PW + j*AW +: AW];
        imat <= in_data[3*PW + NA*AW +: MW];
      end
      crcr_pkg::OP_LOAD: begin
        if (!cmd.seg_end) begin
          pa   <= cmd.far_start ? hp0 : hp1;
          pb   <= hp1;
          pc   <= hp2;
          pd   <= ip;
          fa   <= ha0;
          ta   <= ha1;
          fmat <= hm0;
          tmat <= hm1;
        end else begin
          pa   <= cmd.far_start ? hp1 : hp2;
          pb   <= hp2;
          pc   <= ip;
          pd   <= ip;
          fa   <= ha1;
          ta   <= ia;
          fmat <= hm1;
          tmat <= imat;
        end
      end
      crcr_pkg::OP_COEF: begin
        coef <= coef_next;
        dx   <= {pc[0][PW-1], pc[0]} - {pb[0][PW-1], pb[0]};
        dz   <= {pc[2][PW-1], pc[2]} - {pb[2][PW-1], pb[2]};
        for (int j = 0; j < NA; j++) adiff[j] <= $signed({1'b0, ta[j]}) - $signed({1'b0, fa[j]});
      end
      crcr_pkg::OP_SQZ:   d2 <= prod[crcr_pkg::DISTW-1:0];
      crcr_pkg::OP_SQL:   d2 <= d2 + prod[crcr_pkg::DISTW-1:0];
      crcr_pkg::OP_SINIT: begin
        ssum  <= lsq;
        sstep <= lsq + (lsq << 1);
        sinc  <= lsq << 1;
      end
      crcr_pkg::OP_SSTEP: begin
        ssum  <= ssum + sstep;
        sstep <= sstep + sinc;
      end
      crcr_pkg::OP_NPOW1: n2 <= {{KW{1'b0}}, cmd.n} * {{KW{1'b0}}, cmd.n};
      crcr_pkg::OP_NPOW2: n3 <= {{KW{1'b0}}, n2} * {{(2*KW){1'b0}}, cmd.n};
      crcr_pkg::OP_MONO1: begin
        k2   <= {{KW{1'b0}}, cmd.k} * {{KW{1'b0}}, cmd.k};
        kn2  <= {{KW{1'b0}}, n2} * {{(2*KW){1'b0}}, cmd.k};
        omat <= ({cmd.k, 1'b0} < {1'b0, cmd.n}) ? fmat : tmat;
      end
      crcr_pkg::OP_MONO2: begin
        k3  <= {{KW{1'b0}}, k2} * {{(2*KW){1'b0}}, cmd.k};
        k2n <= {{KW{1'b0}}, k2} * {{(2*KW){1'b0}}, cmd.n};
      end
      crcr_pkg::OP_PMAC: begin
        if (cmd.term == 2'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + prod[ACCW-1:0];
        end
      end
      crcr_pkg::OP_PACC:  acc <= acc + prod[ACCW-1:0];
      crcr_pkg::OP_PSAVE: opos[cmd.axis] <= qsat;
      crcr_pkg::OP_ASAVE: oattr[cmd.attr] <= fa[cmd.attr] + div_q[AW-1:0];
      crcr_pkg::OP_TAIL: begin
        opos  <= ip;
        oattr <= ia;
        omat  <= imat;
      end
      crcr_pkg::OP_SHIFT: begin
        hp0 <= hp1;
        hp1 <= hp2;
        hp2 <= ip;
        ha0 <= ha1;
        ha1 <= ia;
        hm0 <= hm1;
        hm1 <= imat;
      end
      default: ;
    endcase
  end

  // pack the result beat
  always_comb begin
    for (int j = 0; j < 3; j++) out_data[j*PW +: PW] = opos[j];
    for (int j = 0; j < NA; j++) out_data[3*PW + j*AW +: AW] = oattr[j];
    out_data[3*PW + NA*AW +: MW] = omat;
  end

endmodule

[rtl/core/crcr_ctrl.sv]
// Controller: sequences points, segments, vertices and the output handshake.
module crcr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output logic               out_clamped,
  input  crcr_pkg::status_t  status,
  output crcr_pkg::cmd_t     cmd
);

  localparam int KW = crcr_pkg::KW;

  crcr_pkg::state_t  state, state_next;
  logic [1:0]        seen, seen_next;
  logic              last_pt, last_pt_next;
  logic              seg_end, seg_end_next;
  logic              far, far_next;
  logic              clamped, clamped_next;
  logic [KW-1:0]     k, k_next;
  logic [KW-1:0]     n, n_next;
  logic [1:0]        axis, axis_next;
  logic [2:0]        attr, attr_next;
  logic [1:0]        term, term_next;
  crcr_pkg::dp_op_t  op;
  logic              seg_final;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= crcr_pkg::ST_IDLE;
      seen    <= 2'd0;
      last_pt <= 1'b0;
      seg_end <= 1'b0;
      far     <= 1'b0;
      clamped <= 1'b0;
      k       <= '0;
      n       <= '0;
      axis    <= '0;
      attr    <= '0;
      term    <= '0;
    end else begin
      state   <= state_next;
      seen    <= seen_next;
      last_pt <= last_pt_next;
      seg_end <= seg_end_next;
      far     <= far_next;
      clamped <= clamped_next;
      k       <= k_next;
      n       <= n_next;
      axis    <= axis_next;
      attr    <= attr_next;
      term    <= term_next;
    end
  end

  assign seg_final = (k == n - KW'(1));

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    seen_next    = seen;
    last_pt_next = last_pt;
    seg_end_next = seg_end;
    far_next     = far;
    clamped_next = clamped;
    k_next       = k;
    n_next       = n;
    axis_next    = axis;
    attr_next    = attr;
    term_next    = term;
    op           = crcr_pkg::OP_NONE;
    unique case (state)
      crcr_pkg::ST_IDLE: begin
        if (in_valid) begin
          op           = crcr_pkg::OP_LATCH;
          last_pt_next = in_last;
          state_next   = crcr_pkg::ST_DECIDE;
        end
      end
      crcr_pkg::ST_DECIDE: begin
        if (seen >= 2'd2) begin
          seg_end_next = 1'b0;
          far_next     = (seen == 2'd3);
          state_next   = crcr_pkg::ST_LOAD;
        end else if (last_pt && seen == 2'd1) begin
          seg_end_next = 1'b1;
          far_next     = 1'b0;
          state_next   = crcr_pkg::ST_LOAD;
        end else if (last_pt) begin
          state_next = crcr_pkg::ST_TAIL;
        end else begin
          state_next = crcr_pkg::ST_SHIFT;
        end
      end
      crcr_pkg::ST_LOAD: begin
        op         = crcr_pkg::OP_LOAD;
        state_next = crcr_pkg::ST_COEF;
      end
      crcr_pkg::ST_COEF: begin
        op         = crcr_pkg::OP_COEF;
        state_next = crcr_pkg::ST_SQX;
      end
      crcr_pkg::ST_SQX: begin
        op         = crcr_pkg::OP_SQX;
        state_next = crcr_pkg::ST_SQZ;
      end
      crcr_pkg::ST_SQZ: begin
        op         = crcr_pkg::OP_SQZ;
        state_next = crcr_pkg::ST_SQL;
      end
      crcr_pkg::ST_SQL: begin
        op         = crcr_pkg::OP_SQL;
        state_next = crcr_pkg::ST_SINIT;
      end
      crcr_pkg::ST_SINIT: begin
        op         = crcr_pkg::OP_SINIT;
        k_next     = KW'(1);
        state_next = crcr_pkg::ST_SCHK;
      end
      // search the smallest step count whose span covers the chord, saturating at MAX_STEPS
      crcr_pkg::ST_SCHK: begin
        if (status.reached) begin
          n_next       = k;
          clamped_next = 1'b0;
          state_next   = crcr_pkg::ST_NPOW1;
        end else if (k == KW'(crcr_pkg::MAX_STEPS)) begin
          n_next       = k;
          clamped_next = 1'b1;
          state_next   = crcr_pkg::ST_NPOW1;
        end else begin
          op     = crcr_pkg::OP_SSTEP;
          k_next = k + KW'(1);
        end
      end
      crcr_pkg::ST_NPOW1: begin
        op         = crcr_pkg::OP_NPOW1;
        state_next = crcr_pkg::ST_NPOW2;
      end
      crcr_pkg::ST_NPOW2: begin
        op         = crcr_pkg::OP_NPOW2;
        k_next     = '0;
        state_next = crcr_pkg::ST_MONO1;
      end
      crcr_pkg::ST_MONO1: begin
        op         = crcr_pkg::OP_MONO1;
        state_next = crcr_pkg::ST_MONO2;
      end
      crcr_pkg::ST_MONO2: begin
        op         = crcr_pkg::OP_MONO2;
        axis_next  = '0;
        term_next  = '0;
        state_next = crcr_pkg::ST_PMAC;
      end
      crcr_pkg::ST_PMAC: begin
        op = crcr_pkg::OP_PMAC;
        if (term == 2'd3) begin
          state_next = crcr_pkg::ST_PACC;
        end else begin
          term_next = term + 2'd1;
        end
      end
      crcr_pkg::ST_PACC: begin
        op         = crcr_pkg::OP_PACC;
        state_next = crcr_pkg::ST_PDIV;
      end
      crcr_pkg::ST_PDIV: begin
        op         = crcr_pkg::OP_PDIV;
        state_next = crcr_pkg::ST_PWAIT;
      end
      crcr_pkg::ST_PWAIT: begin
        if (status.div_done) begin
          op = crcr_pkg::OP_PSAVE;
          if (axis == 2'd2) begin
            attr_next  = '0;
            state_next = crcr_pkg::ST_AMUL;
          end else begin
            axis_next  = axis + 2'd1;
            term_next  = '0;
            state_next = crcr_pkg::ST_PMAC;
          end
        end
      end
      crcr_pkg::ST_AMUL: begin
        op         = crcr_pkg::OP_AMUL;
        state_next = crcr_pkg::ST_ADIV;
      end
      crcr_pkg::ST_ADIV: begin
        op         = crcr_pkg::OP_ADIV;
        state_next = crcr_pkg::ST_AWAIT;
      end
      crcr_pkg::ST_AWAIT: begin
        if (status.div_done) begin
          op = crcr_pkg::OP_ASAVE;
          if (attr == 3'(crcr_pkg::NATTR - 1)) begin
            state_next = crcr_pkg::ST_OUT;
          end else begin
            attr_next  = attr + 3'd1;
            state_next = crcr_pkg::ST_AMUL;
          end
        end
      end
      // hold the vertex until taken, then advance
      crcr_pkg::ST_OUT: begin
        if (out_ready) begin
          if (!seg_final) begin
            k_next     = k + KW'(1);
            state_next = crcr_pkg::ST_MONO1;
          end else if (!seg_end && last_pt) begin
            seg_end_next = 1'b1;
            far_next     = 1'b1;
            state_next   = crcr_pkg::ST_LOAD;
          end else if (seg_end) begin
            state_next = crcr_pkg::ST_TAIL;
          end else begin
            state_next = crcr_pkg::ST_SHIFT;
          end
        end
      end
      crcr_pkg::ST_TAIL: begin
        op         = crcr_pkg::OP_TAIL;
        state_next = crcr_pkg::ST_TOUT;
      end
      crcr_pkg::ST_TOUT: begin
        if (out_ready) begin
          state_next = crcr_pkg::ST_SHIFT;
        end
      end
      crcr_pkg::ST_SHIFT: begin
        op         = crcr_pkg::OP_SHIFT;
        seen_next  = last_pt ? 2'd0 : ((seen == 2'd3) ? 2'd3 : seen + 2'd1);
        state_next = crcr_pkg::ST_IDLE;
      end
      default: state_next = crcr_pkg::ST_IDLE;
    endcase
  end

  // handshake and sideband outputs
  always_comb begin
    in_ready    = (state == crcr_pkg::ST_IDLE);
    out_valid   = (state == crcr_pkg::ST_OUT) || (state == crcr_pkg::ST_TOUT);
    out_last    = (state == crcr_pkg::ST_TOUT) ||
                  ((state == crcr_pkg::ST_OUT) && seg_final && !seg_end && !last_pt);
    out_clamped = (state == crcr_pkg::ST_OUT) && clamped;
    cmd.op        = op;
    cmd.seg_end   = seg_end;
    cmd.far_start = far;
    cmd.axis      = axis;
    cmd.attr      = attr;
    cmd.term      = term;
    cmd.k         = k;
    cmd.n         = n;
  end

endmodule

[rtl/core/catmull_rom_centreline_resampler_unit.sv]
// Top level of the Catmull-Rom centreline resampler.
//
// Control points arrive on the s_axis stream, one beat per point; tlast marks
// the final point of a section. Resampled vertices leave on m_axis, with
// tlast on the final vertex caused by a point and tuser set when that
// segment's step count was saturated. cfg_we/cfg_wdata write the step length
// (1/256 m), which reset sets to 256.
// A point is taken only while the unit is idle; its vertices lag one point.
// Each point passes through its own steps: take, decide, shift the history.
// Per segment the setup loads the points, forms the coefficients and the
// squared chord, then tries one step count after another (up to 31). Each
// vertex then uses the bit-serial divider eight times (three positions,
// five attributes), with four multiply-accumulate terms per axis on the
// shared multiplier.
// A stalled receiver holds the vertex steady on m_axis and the unit waits.
// Reset (rst, synchronous) empties the point history and returns to idle.
`include "assert_macros.svh"

module catmull_rom_centreline_resampler_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // point_x, point_y, point_z, channel_width, channel_depth, stream_speed,
  // turbulence_in, bed_profile, material_id
  input  logic [crcr_pkg::TDW-1:0]     s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // vertex_x, vertex_y, vertex_z, vertex_width, vertex_depth, vertex_speed,
  // vertex_turbulence, vertex_squareness, vertex_material
  output logic [crcr_pkg::TDW-1:0]     m_axis_tdata,
  output logic                         m_axis_tlast,
  // steps_clamped
  output logic [0:0]                   m_axis_tuser
);

  crcr_pkg::cmd_t    cmd;
  crcr_pkg::status_t status;
  logic              in_beat;
  logic              out_final;

  crcr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_last     (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_last    (m_axis_tlast),
    .out_clamped (m_axis_tuser[0]),
    .status      (status),
    .cmd         (cmd)
  );

  crcr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

  // handshake events watched by the assertions
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_final = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  // the unit never offers a vertex while it can take a point
  `CRCR_ASSERT_IMPL(a_one_side, clk, rst, m_axis_tvalid, !s_axis_tready, "input open")
  // a taken point keeps the input closed on the next cycle
  `CRCR_ASSERT_NEXT(a_busy_after_take, clk, rst, in_beat, !s_axis_tready, "input open")
  // the final vertex of a point ends the output run
  `CRCR_ASSERT_NEXT(a_last_ends_run, clk, rst, out_final, !m_axis_tvalid, "vertex after final")

endmodule
